// ----- rtl/pre_pkg.sv -----
// shared types and constants for the page replacement engine
package pre_pkg;
    localparam int ENTRIES   = 8;
    localparam int PAGE_BITS = 20;
    localparam int IDX_BITS  = $clog2(ENTRIES);
    localparam int AGE_BITS  = 16;
    localparam int FAULT_BITS = 32;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [IDX_BITS-1:0]  t_idx;
    typedef logic [AGE_BITS-1:0]  t_age;

    // replacement policy codes
    typedef enum logic [1:0] {
        POL_LRU  = 2'd0,
        POL_FIFO = 2'd1,
        POL_SC   = 2'd2,
        POL_SC3  = 2'd3
    } t_policy;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic  shift;      // fifo shift-down, last cell loads page
        logic  write;      // write page into target slot
        logic  set_valid;
        t_idx  target;
        logic  age_clr;    // clear target age
        logic  age_inc;    // age every valid slot
        logic  ref_set;    // set target ref bit
        logic  ref_clr;    // clear target ref bit
        t_page page;
    } t_cell_cmd;

    // what one cell shows to the controller
    typedef struct packed {
        logic  valid;
        t_page page;
        t_age  age;
        logic  ref_bit;
    } t_cell_view;
endpackage

// ----- rtl/page_replacement_engine.sv -----
// top level of the page replacement engine: controller and row of slot cells
//  channel | ports                                 | handshake
//  in      | i_page_number                         | start & !busy
//  cfg     | i_cfg_we, i_cfg_data (policy)         | i_cfg_we
//  out     | o_hit, o_slot, o_fault_count          | o_strobe, one cycle
// a reference is scanned one slot per cycle for a hit or a slot to fill; a
// second-chance eviction then adds a sweep of the hand over the ref bits
// synchronous active-low reset empties all slots and selects second chance
// the result strobe lasts one cycle; the receiver cannot stall
module page_replacement_engine
    import pre_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [19:0]           i_page_number,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_data,
    output logic                  o_strobe,
    output logic                  o_hit,
    output logic [2:0]            o_slot,
    output logic [31:0]           o_fault_count
);
    t_cell_cmd  cmd;
    t_cell_view views [ENTRIES];

    // controller
    pre_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .busy,
        .i_page(t_page'(i_page_number)),
        .i_cfg_we, .i_cfg_data,
        .i_views(views), .o_cmd(cmd),
        .o_strobe, .o_hit, .o_slot, .o_fault_count
    );

    // row of cells, each fed the page of its upper neighbor
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        pre_cell u_cell (
            .i_clk, .i_rst_n,
            .i_index(t_idx'(g)),
            .i_cmd(cmd),
            .i_next_page(views[(g + 1) % ENTRIES].page),
            .o_view(views[g])
        );
    end
endmodule

// ----- rtl/pre_cell.sv -----
// one slot cell: valid, page, age and reference bit
module pre_cell
    import pre_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_idx       i_index,
    input  t_cell_cmd  i_cmd,
    input  t_page      i_next_page,
    output t_cell_view o_view
);
    logic  r_valid;
    t_page r_page;
    t_age  r_age;
    logic  r_ref;
    logic  sel;
    logic  last;
    logic  fill;

    assign sel  = (i_cmd.target == i_index);
    assign last = (i_index == t_idx'(ENTRIES - 1));
    assign fill = i_cmd.write && sel && i_cmd.set_valid;

    // control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
            r_ref   <= 1'b0;
        end else begin
            if (fill) begin
                r_valid <= 1'b1;
            end
            // a cleared or newly filled slot still takes this beat's aging
            if (i_cmd.age_clr && sel) begin
                r_age <= i_cmd.age_inc ? t_age'(1) : '0;
            end else if (i_cmd.age_inc && (r_valid || fill) && r_age != AGE_MAX) begin
                r_age <= r_age + 1'b1;
            end
            if (i_cmd.ref_set && sel) begin
                r_ref <= 1'b1;
            end else if (i_cmd.ref_clr && sel) begin
                r_ref <= 1'b0;
            end
        end
    end

    // page payload, shifts from the neighbor above in fifo mode
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_page <= last ? i_cmd.page : i_next_page;
        end else if (i_cmd.write && sel) begin
            r_page <= i_cmd.page;
        end
    end

    assign o_view = '{valid: r_valid, page: r_page, age: r_age, ref_bit: r_ref};
endmodule

// ----- rtl/pre_ctrl.sv -----
// sequencer: scans cells one per cycle and issues commands
module pre_ctrl
    import pre_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_page                 i_page,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_data,
    input  t_cell_view            i_views [ENTRIES],
    output t_cell_cmd             o_cmd,
    output logic                  o_strobe,
    output logic                  o_hit,
    output logic [2:0]            o_slot,
    output logic [FAULT_BITS-1:0] o_fault_count
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_HAND, S_DONE} t_state;

    localparam int CNT_BITS = $clog2(ENTRIES + 1);

    t_state                r_state;
    t_policy               r_policy;
    t_page                 r_page;
    logic [CNT_BITS-1:0]   r_k;
    t_idx                  r_oldest;
    t_age                  r_top;
    t_idx                  r_hand;
    logic [FAULT_BITS-1:0] r_fault;
    t_cell_cmd             n_cmd;
    t_cell_view            cur;
    t_idx                  k_idx;
    logic                  at_end;
    logic                  fault_sat;

    assign k_idx     = r_k[IDX_BITS-1:0];
    assign cur       = i_views[k_idx];
    assign at_end    = (r_k == CNT_BITS'(ENTRIES));
    assign fault_sat = (r_fault == '1);
    assign busy      = (r_state != S_IDLE);
    assign o_fault_count = r_fault;

    // first empty slot, or the last slot when full (fifo)
    function automatic t_idx first_empty(input t_cell_view v [ENTRIES]);
        t_idx r;
        r = t_idx'(ENTRIES - 1);
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!v[i].valid) r = t_idx'(i);
        end
        return r;
    endfunction

    // sequencer and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= POL_SC;
            r_hand   <= '0;
            r_fault  <= '0;
            o_strobe <= 1'b0;
            o_hit    <= 1'b0;
            o_slot   <= '0;
            o_cmd    <= '0;
        end else begin
            o_strobe <= 1'b0;
            o_cmd    <= n_cmd;
            if (i_cfg_we) begin
                r_policy <= t_policy'(i_cfg_data);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_page   <= i_page;
                        r_k      <= '0;
                        r_oldest <= '0;
                        r_top    <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!at_end && cur.valid && cur.page == r_page) begin
                        o_hit  <= 1'b1;
                        o_slot <= 3'(k_idx);
                        r_state <= S_DONE;
                    end else if (!at_end && (cur.valid || r_policy == POL_FIFO)) begin
                        if (cur.age > r_top) begin
                            r_top    <= cur.age;
                            r_oldest <= k_idx;
                        end
                        r_k <= r_k + 1'b1;
                    end else begin
                        // miss
                        o_hit <= 1'b0;
                        if (!fault_sat) r_fault <= r_fault + 1'b1;
                        if (r_policy == POL_FIFO) begin
                            o_slot  <= 3'(first_empty(i_views));
                            r_state <= S_DONE;
                        end else if (!at_end) begin
                            o_slot <= 3'(k_idx);
                            if (r_policy != POL_LRU) begin
                                r_hand <= (r_hand == t_idx'(ENTRIES - 1)) ? '0
                                                                          : r_hand + 1'b1;
                            end
                            r_state <= S_DONE;
                        end else if (r_policy == POL_LRU) begin
                            o_slot  <= 3'(r_oldest);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_HAND;
                        end
                    end
                end
                S_HAND: begin
                    if (i_views[r_hand].ref_bit) begin
                        r_hand <= (r_hand == t_idx'(ENTRIES - 1)) ? '0 : r_hand + 1'b1;
                    end else begin
                        o_slot  <= 3'(r_hand);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    o_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // command for the cells, computed this cycle and registered into o_cmd
    always_comb begin
        n_cmd = '0;
        n_cmd.page = r_page;
        if (r_state == S_SCAN) begin
            if (!at_end && cur.valid && cur.page == r_page) begin
                n_cmd.target = k_idx;
                if (r_policy == POL_LRU) begin
                    n_cmd.age_clr = 1'b1;
                    n_cmd.age_inc = 1'b1;
                end else if (r_policy != POL_FIFO) begin
                    n_cmd.ref_set = 1'b1;
                end
            end else if (!at_end && (cur.valid || r_policy == POL_FIFO)) begin
                n_cmd = n_cmd;
            end else if (r_policy == POL_FIFO) begin
                if (i_views[ENTRIES-1].valid) begin
                    n_cmd.shift = 1'b1;
                end else begin
                    n_cmd.write     = 1'b1;
                    n_cmd.set_valid = 1'b1;
                    n_cmd.target    = first_empty(i_views);
                end
            end else if (!at_end) begin
                n_cmd.write     = 1'b1;
                n_cmd.set_valid = 1'b1;
                n_cmd.target    = k_idx;
                n_cmd.ref_clr   = (r_policy != POL_LRU);
                n_cmd.age_inc   = (r_policy == POL_LRU);
            end else if (r_policy == POL_LRU) begin
                n_cmd.write   = 1'b1;
                n_cmd.target  = r_oldest;
                n_cmd.age_clr = 1'b1;
                n_cmd.age_inc = 1'b1;
            end
        end else if (r_state == S_HAND) begin
            n_cmd.target = r_hand;
            if (i_views[r_hand].ref_bit) begin
                n_cmd.ref_clr = 1'b1;
            end else begin
                n_cmd.write   = 1'b1;
                n_cmd.ref_set = 1'b1;
            end
        end
    end

    // a result only follows a busy period
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("strobe without work");
    // fault count never drops
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_fault >= $past(r_fault))
        else $error("fault count went down");
    // a hit never counts a fault
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_hit && $past(i_rst_n, 3)) |-> r_fault == $past(r_fault))
        else $error("hit changed fault count");
endmodule
